@@ rtl/f2c_pkg.sv @@
// ----------------------------------------------------------------------------
// f2c_pkg
// Types, widths and helpers shared by the polyline Frenet-to-XY unit.
// ----------------------------------------------------------------------------
`default_nettype none

package f2c_pkg;

	// Request actions.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Widths that follow from the fixed field formats.
	localparam int CNT_W   = 11;  // point count and segment counter
	localparam int COORD_W = 32;  // one coordinate
	localparam int DIFF_W  = 33;  // difference of two coordinates
	localparam int MAG_W   = 32;  // magnitude of a difference
	localparam int LEN_W   = 33;  // segment length
	localparam int ACC_W   = 45;  // signed running length, 1023 segments
	localparam int QUOT_W  = 63;  // signed quotient, magnitude capped at 2^61
	localparam int SUM_W   = 64;  // signed coordinate sum before saturation

	typedef struct packed {
		logic        action;
		logic [9:0]  point_index;
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [31:0] station_s;
		logic [31:0] lateral_d;
	} req_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic        out_of_range;
	} rsp_t;

	// Saturate a signed sum to the signed 32-bit range.
	function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi) begin
			return 32'h7FFF_FFFF;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/f2c_path_mem.sv @@
// ----------------------------------------------------------------------------
// f2c_path_mem
// Path point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module f2c_path_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire          clk,
	input  wire          wr_en,
	input  wire [AW-1:0] wr_addr,
	input  wire [63:0]   wr_data,
	input  wire          rd_en,
	input  wire [AW-1:0] rd_addr,
	output logic [63:0]  rd_data
);

	// Each entry holds {x, y}.
	logic [63:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data is registered, so it appears in the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/f2c_sqrt.sv @@
// ----------------------------------------------------------------------------
// f2c_sqrt
// Iterative integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module f2c_sqrt (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire [63:0]  radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] op_q;
	logic [63:0] res_q;
	logic [63:0] one_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + one_q;

	// Digit-by-digit root: two radicand bits per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= radicand;
			res_q <= '0;
			one_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (op_q >= trial) begin
				op_q  <= op_q - trial;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

`default_nettype wire

@@ rtl/f2c_muldiv.sv @@
// ----------------------------------------------------------------------------
// f2c_muldiv
// Signed a*b/c truncated toward zero, magnitude capped at 2^61.
// A multiply step, then a restoring divide at one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module f2c_muldiv (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire signed [f2c_pkg::DIFF_W-1:0]     a,
	input  wire signed [f2c_pkg::DIFF_W-1:0]     b,
	input  wire [f2c_pkg::LEN_W-1:0]             c,
	output logic                                 done,
	output logic signed [f2c_pkg::QUOT_W-1:0]    quot
);

	import f2c_pkg::*;

	localparam int PW = 2 * DIFF_W;   // product width
	localparam int RW = LEN_W + 1;    // partial remainder width
	localparam logic [PW-1:0] CAP = PW'(1) << 61;

	logic [DIFF_W-1:0] ma_q;
	logic [DIFF_W-1:0] mb_q;
	logic [LEN_W-1:0]  c_q;
	logic              neg_q;
	logic [PW-1:0]     prod_q;
	logic [LEN_W-1:0]  rem_q;
	logic [PW-1:0]     q_q;
	logic [6:0]        cnt_q;
	logic              mul_q;
	logic              div_q;
	logic              done_q;
	logic [RW-1:0]     r_sh;
	logic              q_bit;
	logic [61:0]       q_cap;

	// Shift in the next product bit and trial-subtract the divisor.
	assign r_sh  = {rem_q, prod_q[PW-1]};
	assign q_bit = (r_sh >= RW'(c_q));

	// Control sequence: multiply once, then PW divide steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				div_q <= 1'b1;
				cnt_q <= '0;
			end else if (div_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(PW - 1)) begin
					div_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
			mb_q  <= b[DIFF_W-1] ? DIFF_W'(-b) : DIFF_W'(b);
			c_q   <= c;
			neg_q <= a[DIFF_W-1] ^ b[DIFF_W-1];
		end else if (mul_q) begin
			prod_q <= ma_q * mb_q;
			rem_q  <= '0;
			q_q    <= '0;
		end else if (div_q) begin
			rem_q  <= q_bit ? LEN_W'(r_sh - RW'(c_q)) : r_sh[LEN_W-1:0];
			q_q    <= {q_q[PW-2:0], q_bit};
			prod_q <= prod_q << 1;
		end
	end

	// Cap the magnitude and apply the sign.
	assign q_cap = (q_q >= CAP) ? 62'(CAP) : q_q[61:0];
	assign quot  = neg_q ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
	assign done  = done_q;

endmodule

`default_nettype wire

@@ rtl/frenet_to_cartesian_polyline_unit.sv @@
// ----------------------------------------------------------------------------
// frenet_to_cartesian_polyline_unit
// Polyline path store with Frenet (s, d) to Cartesian (x, y) conversion.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                          Moves
//  -------  -------------------------------  ------------------------------
//  req      req_valid, req_stall, req        point load or (s, d) query
//  rsp      rsp_valid, rsp_stall, rsp        converted point, range flag
//  cfg      cfg_wr_en, cfg_wr_data           point_count register
//
//  A point load with an index below MAX_POINTS is written to the store when it
//  is taken. A query reads the first point, then for each segment walked reads
//  the next point, squares the two differences, starts the 32-step square root
//  unit and waits for it; when the hit segment has nonzero length it runs the
//  four multiply-divides, and then it emits. One request is in flight at a time;
//  req_stall is high while a query runs. A finished result waits in the output
//  register while the next request is taken. Reset clears control state and sets point_count to 2.
//
`default_nettype none

module frenet_to_cartesian_polyline_unit #(
	parameter int MAX_POINTS = 1024
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire f2c_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output f2c_pkg::rsp_t       rsp,
	input  wire                 cfg_wr_en,
	input  wire [10:0]          cfg_wr_data
);

	import f2c_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_RD0  = 10'b00_0000_0010,
		ST_RDN  = 10'b00_0000_0100,
		ST_SQA  = 10'b00_0000_1000,
		ST_SQB  = 10'b00_0001_0000,
		ST_SQS  = 10'b00_0010_0000,
		ST_SQW  = 10'b00_0100_0000,
		ST_MDS  = 10'b00_1000_0000,
		ST_MDW  = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]         point_count_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         seg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       s_q;
	logic signed [31:0]       d_q;
	logic signed [31:0]       prev_x_q;
	logic signed [31:0]       prev_y_q;
	logic signed [31:0]       cur_x_q;
	logic signed [31:0]       cur_y_q;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic [63:0]              a2_q;
	logic [63:0]              b2_q;
	logic                     ovf_q;
	logic [LEN_W-1:0]         len_q;
	logic signed [DIFF_W-1:0] rem_q;
	logic [1:0]               k_q;
	logic signed [SUM_W-1:0]  bx_q;
	logic signed [SUM_W-1:0]  by_q;
	logic                     oor_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic              req_take;
	logic              rsp_free;
	logic [CNT_W-1:0]  eff_count;
	logic              load_ok;
	logic              mem_wr_en;
	logic              mem_rd_en;
	logic [AW-1:0]     mem_rd_addr;
	logic [63:0]       mem_rd_data;
	logic [MAG_W-1:0]  sq_op;
	logic [63:0]       sq_prod;
	logic [64:0]       sq_sum;
	logic [63:0]       radicand;
	logic              sqrt_done;
	logic [31:0]       sqrt_root;
	logic [LEN_W-1:0]  len;
	logic signed [ACC_W-1:0] reach;
	logic              hit;
	logic              advance;
	logic              md_start;
	logic signed [DIFF_W-1:0] md_a;
	logic signed [DIFF_W-1:0] md_b;
	logic              md_done;
	logic signed [QUOT_W-1:0] md_quot;
	logic signed [SUM_W-1:0]  md_ext;

	// Handshake.
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Effective point count and load range check.
	assign eff_count = (32'(point_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : point_count_q;
	assign load_ok   = (32'(req.point_index) < MAX_POINTS);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(2);
		end else if (cfg_wr_en) begin
			point_count_q <= cfg_wr_data;
		end
	end

	// Path store access.
	assign mem_wr_en = req_take && (req.action == ACT_LOAD) && load_ok;
	assign advance   = (state_q == ST_SQW) && sqrt_done && !hit && (seg_q + 1'b1 != cnt_q);

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		if (req_take && (req.action == ACT_QUERY)) begin
			mem_rd_en = 1'b1;
		end else if (state_q == ST_RD0) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = AW'(seg_q);
		end else if (advance) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = AW'(seg_q + 1'b1);
		end
	end

	f2c_path_mem #(
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (AW'(req.point_index)),
		.wr_data ({req.point_x, req.point_y}),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Shared squarer for the segment length.
	assign sq_op   = (state_q == ST_SQA) ? MAG_W'(dx_q[DIFF_W-1] ? -dx_q : dx_q)
	                                     : MAG_W'(dy_q[DIFF_W-1] ? -dy_q : dy_q);
	assign sq_prod = sq_op * sq_op;
	assign sq_sum  = {1'b0, a2_q} + {1'b0, b2_q};
	assign radicand = sq_sum[64] ? {1'b0, sq_sum[64:2]} : sq_sum[63:0];

	f2c_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_SQS),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Length of this segment and the hit test against s.
	assign len   = ovf_q ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
	assign reach = acc_q + ACC_W'(len);
	assign hit   = (reach >= ACC_W'(s_q));

	// Operands of the four interpolation terms.
	always_comb begin
		unique case (k_q)
			2'd0: begin md_a = rem_q;            md_b = dx_q; end
			2'd1: begin md_a = DIFF_W'(d_q);     md_b = dy_q; end
			2'd2: begin md_a = rem_q;            md_b = dy_q; end
			default: begin md_a = DIFF_W'(d_q);  md_b = dx_q; end
		endcase
	end

	assign md_start = (state_q == ST_MDS);

	f2c_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (md_a),
		.b      (md_b),
		.c      (len_q),
		.done   (md_done),
		.quot   (md_quot)
	);

	assign md_ext = SUM_W'(md_quot);

	// Query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_take && (req.action == ACT_QUERY)) begin
						state_q <= (eff_count < CNT_W'(2)) ? ST_EMIT : ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RDN;
				ST_RDN: state_q <= ST_SQA;
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_SQW;
				ST_SQW: begin
					if (sqrt_done) begin
						if (hit) begin
							state_q <= (len == '0) ? ST_EMIT : ST_MDS;
						end else if (advance) begin
							state_q <= ST_RDN;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MDS: state_q <= ST_MDW;
				ST_MDW: begin
					if (md_done) begin
						state_q <= (k_q == 2'd3) ? ST_EMIT : ST_MDS;
					end
				end
				ST_EMIT: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				s_q   <= req.station_s;
				d_q   <= req.lateral_d;
				cnt_q <= eff_count;
				seg_q <= CNT_W'(1);
				acc_q <= '0;
				bx_q  <= '0;
				by_q  <= '0;
				oor_q <= 1'b1;
			end
			ST_RD0: begin
				prev_x_q <= mem_rd_data[63:32];
				prev_y_q <= mem_rd_data[31:0];
			end
			ST_RDN: begin
				cur_x_q <= mem_rd_data[63:32];
				cur_y_q <= mem_rd_data[31:0];
				dx_q <= DIFF_W'($signed(mem_rd_data[63:32])) - DIFF_W'(prev_x_q);
				dy_q <= DIFF_W'($signed(mem_rd_data[31:0])) - DIFF_W'(prev_y_q);
			end
			ST_SQA: a2_q <= sq_prod;
			ST_SQB: b2_q <= sq_prod;
			ST_SQS: ovf_q <= sq_sum[64];
			ST_SQW: begin
				if (sqrt_done) begin
					if (hit) begin
						len_q <= len;
						rem_q <= DIFF_W'(ACC_W'(s_q) - acc_q);
						k_q   <= 2'd0;
						bx_q  <= SUM_W'(prev_x_q);
						by_q  <= SUM_W'(prev_y_q);
						oor_q <= 1'b0;
					end else begin
						acc_q    <= reach;
						seg_q    <= seg_q + 1'b1;
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
					end
				end
			end
			ST_MDW: begin
				if (md_done) begin
					unique case (k_q)
						2'd0: bx_q <= bx_q + md_ext;
						2'd1: bx_q <= bx_q - md_ext;
						2'd2: by_q <= by_q + md_ext;
						default: by_q <= by_q + md_ext;
					endcase
					k_q <= k_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && rsp_free) begin
			rsp_q.out_x        <= sat32(bx_q);
			rsp_q.out_y        <= sat32(by_q);
			rsp_q.out_of_range <= oor_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> rsp.out_x == '0 && rsp.out_y == '0)
		else $error("out-of-range result with nonzero coordinates");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

	a_seg_in_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDN |-> seg_q < cnt_q)
		else $error("segment walk ran past the path end");

	a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_SQW)
		else $error("square root finished outside its wait step");

endmodule

`default_nettype wire
